FILE: src/ubox_pkg.sv
// ----------------------------------------------------------------------------
// Unit box intersection package
// Shared widths, face tables, register indexes, the ray bundle type and a magnitude helper.
// ----------------------------------------------------------------------------
`default_nettype none

package ubox_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int NUM_FACES     = 6;
	localparam int NUM_AXES      = 3;
	localparam int WORD_W        = 32;
	localparam int Q_W           = 31;
	localparam int EPS_W         = 16;
	localparam int UV_W          = 18;
	localparam int FACE_W        = 3;

	localparam logic [Q_W-1:0] FAR_LIMIT = '1;

	localparam logic CFG_VISIBLE = 1'b0;
	localparam logic CFG_EPSILON = 1'b1;

	localparam logic [1:0] AX_X = 2'd0;
	localparam logic [1:0] AX_Y = 2'd1;
	localparam logic [1:0] AX_Z = 2'd2;

	localparam logic [1:0] FACE_AXIS [NUM_FACES] = '{AX_Z, AX_Z, AX_X, AX_X, AX_Y, AX_Y};
	localparam logic       FACE_POS  [NUM_FACES] = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1};
	localparam logic [1:0] FACE_UAX  [NUM_FACES] = '{AX_X, AX_X, AX_Z, AX_Z, AX_X, AX_X};
	localparam logic [1:0] FACE_VAX  [NUM_FACES] = '{AX_Y, AX_Y, AX_Y, AX_Y, AX_Z, AX_Z};

	typedef struct packed {
		logic [NUM_AXES-1:0][WORD_W-1:0] org;
		logic [NUM_AXES-1:0][WORD_W-1:0] dir;
	} ray_t;

	function automatic logic [WORD_W-1:0] mag32(input logic [WORD_W-1:0] x);
		mag32 = x[WORD_W-1] ? (~x + 1'b1) : x;
	endfunction

endpackage

`default_nettype wire

FILE: src/ubox_div.sv
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per register stage; the partial remainder enters below
// the divisor, so the quotient fits in Q_W bits.
// ----------------------------------------------------------------------------
`default_nettype none

module ubox_div import ubox_pkg::*; (
	input  logic              clk,
	input  logic              en,
	input  logic [WORD_W-1:0] p_in,
	input  logic [Q_W-1:0]    l_in,
	input  logic [WORD_W-1:0] mk_in,
	output logic [Q_W-1:0]    q
);

	logic [WORD_W-1:0] p_q  [Q_W];
	logic [Q_W-1:0]    l_q  [Q_W];
	logic [WORD_W-1:0] mk_q [Q_W];
	logic [Q_W-1:0]    q_q  [Q_W];

	for (genvar j = 0; j < Q_W; j++) begin : g_step
		logic [WORD_W-1:0] p_prev;
		logic [WORD_W-1:0] mk_prev;
		logic [Q_W-1:0]    l_prev;
		logic [Q_W-1:0]    q_prev;
		logic [WORD_W:0]   trial;
		logic              take;

		if (j == 0) begin : g_first
			assign p_prev  = p_in;
			assign mk_prev = mk_in;
			assign l_prev  = l_in;
			assign q_prev  = '0;
		end else begin : g_next
			assign p_prev  = p_q[j-1];
			assign mk_prev = mk_q[j-1];
			assign l_prev  = l_q[j-1];
			assign q_prev  = q_q[j-1];
		end

		assign trial = {p_prev, l_prev[Q_W-1]};
		assign take  = trial >= {1'b0, mk_prev};

		always_ff @(posedge clk) begin
			if (en) begin
				p_q[j]  <= take ? WORD_W'(trial - {1'b0, mk_prev}) : trial[WORD_W-1:0];
				l_q[j]  <= {l_prev[Q_W-2:0], 1'b0};
				mk_q[j] <= mk_prev;
				q_q[j]  <= {q_prev[Q_W-2:0], take};
			end
		end
	end

	assign q = q_q[Q_W-1];

endmodule

`default_nettype wire

FILE: src/unit_box_ray_intersect.sv
// ----------------------------------------------------------------------------
// Ray against unit box
// Finds the nearest face of the cube from -1 to +1 hit by a local-space ray.
// ----------------------------------------------------------------------------
// One ray enters per cycle unless the pipeline holds, passing through two input
// and setup stages, 31 stages of the per-face restoring dividers (one
// quotient bit each), and six stages for the in-face test, the nearest-face
// selection and the hit point. The whole pipeline holds while a result beat
// waits on out_stall.
`default_nettype none

module unit_box_ray_intersect import ubox_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic                     cfg_index,
	input  logic [EPS_W-1:0]         cfg_data,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic signed [WORD_W-1:0] origin_x,
	input  logic signed [WORD_W-1:0] origin_y,
	input  logic signed [WORD_W-1:0] origin_z,
	input  logic signed [WORD_W-1:0] dir_x,
	input  logic signed [WORD_W-1:0] dir_y,
	input  logic signed [WORD_W-1:0] dir_z,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic                     hit,
	output logic [FACE_W-1:0]        face,
	output logic [Q_W-1:0]           hit_t,
	output logic signed [UV_W-1:0]   face_u,
	output logic signed [UV_W-1:0]   face_v,
	output logic signed [WORD_W-1:0] point_x,
	output logic signed [WORD_W-1:0] point_y,
	output logic signed [WORD_W-1:0] point_z
);

	localparam int N_W    = WORD_W + 2;
	localparam int DW     = WORD_W + FRAC_BITS;
	localparam int PROD_W = WORD_W + Q_W;
	localparam int PRW    = PROD_W - FRAC_BITS;
	localparam int SW     = PRW + 2;

	localparam logic signed [N_W-1:0] ONE_N = N_W'(1) << FRAC_BITS;
	localparam logic signed [SW-1:0]  ONE_S = SW'(1) << FRAC_BITS;
	localparam logic signed [SW-1:0]  P_MAX = SW'(2147483647);
	localparam logic signed [SW-1:0]  P_MIN = ~P_MAX;

	logic             visible_q;
	logic [EPS_W-1:0] eps_q;
	logic             en;
	logic             out_valid_q;

	assign en        = !(out_valid_q && out_stall);
	assign in_stall  = out_valid_q && out_stall;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			visible_q <= 1'b1;
			eps_q     <= EPS_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_VISIBLE: visible_q <= cfg_data[0];
				CFG_EPSILON: eps_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// Stage 1: input register.
	logic v_s1;
	ray_t ray_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && in_valid) begin
			ray_s1.org <= {origin_z, origin_y, origin_x};
			ray_s1.dir <= {dir_z, dir_y, dir_x};
		end
	end

	// Stage 2: face distances set up for division.
	logic                 v_s2;
	ray_t                 ray_s2;
	logic [NUM_FACES-1:0] ok_s2;
	logic [WORD_W-1:0]    p_s2  [NUM_FACES];
	logic [Q_W-1:0]       l_s2  [NUM_FACES];
	logic [WORD_W-1:0]    mk_s2 [NUM_FACES];

	for (genvar i = 0; i < NUM_FACES; i++) begin : g_setup
		logic signed [WORD_W-1:0] a_c;
		logic signed [WORD_W-1:0] k_c;
		logic signed [N_W-1:0]    n_c;
		logic [WORD_W-1:0]        mn_c;
		logic [WORD_W-1:0]        mk_c;
		logic [DW-1:0]            d_c;
		logic                     ok_c;

		assign a_c  = ray_s1.org[FACE_AXIS[i]];
		assign k_c  = ray_s1.dir[FACE_AXIS[i]];
		assign n_c  = (FACE_POS[i] ? ONE_N : -ONE_N) - N_W'(a_c);
		assign mn_c = n_c[N_W-1] ? WORD_W'(-n_c) : n_c[WORD_W-1:0];
		assign mk_c = mag32(k_c);
		assign d_c  = DW'(mn_c) << FRAC_BITS;
		assign ok_c = visible_q && (k_c != '0) && (mk_c >= WORD_W'(eps_q))
			&& (n_c != '0) && (n_c[N_W-1] == k_c[WORD_W-1])
			&& (WORD_W'(d_c[DW-1:Q_W]) < mk_c);

		always_ff @(posedge clk) begin
			if (en) begin
				ok_s2[i] <= ok_c;
				p_s2[i]  <= WORD_W'(d_c[DW-1:Q_W]);
				l_s2[i]  <= d_c[Q_W-1:0];
				mk_s2[i] <= mk_c;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ray_s2 <= ray_s1;
		end
	end

	// Division stages, with the ray carried alongside.
	logic [Q_W-1:0]       q_w    [NUM_FACES];
	logic                 v_dl_q [Q_W];
	ray_t                 ray_dl_q [Q_W];
	logic [NUM_FACES-1:0] ok_dl_q  [Q_W];

	for (genvar i = 0; i < NUM_FACES; i++) begin : g_div
		ubox_div u_div (
			.clk   (clk),
			.en    (en),
			.p_in  (p_s2[i]),
			.l_in  (l_s2[i]),
			.mk_in (mk_s2[i]),
			.q     (q_w[i])
		);
	end

	for (genvar j = 0; j < Q_W; j++) begin : g_dly
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_dl_q[j] <= 1'b0;
			end else if (en) begin
				v_dl_q[j] <= (j == 0) ? v_s2 : v_dl_q[(j == 0) ? 0 : j-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				ray_dl_q[j] <= (j == 0) ? ray_s2 : ray_dl_q[(j == 0) ? 0 : j-1];
				ok_dl_q[j]  <= (j == 0) ? ok_s2 : ok_dl_q[(j == 0) ? 0 : j-1];
			end
		end
	end

	// Stage 3: products of the in-face directions with the distance.
	logic                 v_s3;
	ray_t                 ray_s3;
	logic [NUM_FACES-1:0] ok_s3;
	logic [Q_W-1:0]       t_s3  [NUM_FACES];
	logic [PROD_W-1:0]    pu_s3 [NUM_FACES];
	logic [PROD_W-1:0]    pv_s3 [NUM_FACES];

	// Stage 4: in-face coordinates and the in-face test.
	logic                 v_s4;
	logic [NUM_FACES-1:0] h_s4;
	logic [Q_W-1:0]       t_s4 [NUM_FACES];
	logic [UV_W-1:0]      u_s4 [NUM_FACES];
	logic [UV_W-1:0]      v_s4c [NUM_FACES];
	ray_t                 ray_s4;

	for (genvar i = 0; i < NUM_FACES; i++) begin : g_face
		logic [WORD_W-1:0]     du_c;
		logic [WORD_W-1:0]     dv_c;
		logic                  tok_c;
		logic [PRW-1:0]        mu_c;
		logic [PRW-1:0]        mv_c;
		logic signed [SW-1:0]  u_c;
		logic signed [SW-1:0]  v_c;
		logic [SW-1:0]         su_c;
		logic [SW-1:0]         sv_c;

		assign du_c  = ray_dl_q[Q_W-1].dir[FACE_UAX[i]];
		assign dv_c  = ray_dl_q[Q_W-1].dir[FACE_VAX[i]];
		assign tok_c = ok_dl_q[Q_W-1][i] && (q_w[i] != '0) && (q_w[i] != FAR_LIMIT);

		always_ff @(posedge clk) begin
			if (en) begin
				ok_s3[i] <= tok_c;
				t_s3[i]  <= q_w[i];
				pu_s3[i] <= PROD_W'(mag32(du_c)) * PROD_W'(q_w[i]);
				pv_s3[i] <= PROD_W'(mag32(dv_c)) * PROD_W'(q_w[i]);
			end
		end

		assign mu_c = pu_s3[i][PROD_W-1:FRAC_BITS];
		assign mv_c = pv_s3[i][PROD_W-1:FRAC_BITS];
		assign su_c = ray_s3.dir[FACE_UAX[i]][WORD_W-1] ? -SW'(mu_c) : SW'(mu_c);
		assign sv_c = ray_s3.dir[FACE_VAX[i]][WORD_W-1] ? -SW'(mv_c) : SW'(mv_c);
		assign u_c  = su_c + SW'($signed(ray_s3.org[FACE_UAX[i]]));
		assign v_c  = sv_c + SW'($signed(ray_s3.org[FACE_VAX[i]]));

		always_ff @(posedge clk) begin
			if (en) begin
				h_s4[i]  <= ok_s3[i] && (u_c <= ONE_S) && (u_c >= -ONE_S)
					&& (v_c <= ONE_S) && (v_c >= -ONE_S);
				t_s4[i]  <= t_s3[i];
				u_s4[i]  <= u_c[UV_W-1:0];
				v_s4c[i] <= v_c[UV_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_dl_q[Q_W-1];
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ray_s3 <= ray_dl_q[Q_W-1];
			ray_s4 <= ray_s3;
		end
	end

	// Stage 5: nearest of each face pair; the lower face wins a tie.
	localparam int NUM_PAIRS = NUM_FACES / 2;

	logic                 v_s5;
	ray_t                 ray_s5;
	logic [NUM_PAIRS-1:0] ch_s5;
	logic [FACE_W-1:0]    cf_s5 [NUM_PAIRS];
	logic [Q_W-1:0]       ct_s5 [NUM_PAIRS];
	logic [UV_W-1:0]      cu_s5 [NUM_PAIRS];
	logic [UV_W-1:0]      cv_s5 [NUM_PAIRS];

	for (genvar p = 0; p < NUM_PAIRS; p++) begin : g_pair
		logic take_hi;

		assign take_hi = h_s4[2*p+1] && (!h_s4[2*p] || (t_s4[2*p+1] < t_s4[2*p]));

		always_ff @(posedge clk) begin
			if (en) begin
				ch_s5[p] <= h_s4[2*p] || h_s4[2*p+1];
				cf_s5[p] <= take_hi ? FACE_W'(2*p+1) : FACE_W'(2*p);
				ct_s5[p] <= take_hi ? t_s4[2*p+1] : t_s4[2*p];
				cu_s5[p] <= take_hi ? u_s4[2*p+1] : u_s4[2*p];
				cv_s5[p] <= take_hi ? v_s4c[2*p+1] : v_s4c[2*p];
			end
		end
	end

	// Stage 6: nearest over the three pairs.
	logic              v_s6;
	ray_t              ray_s6;
	logic              bh_s6;
	logic [FACE_W-1:0] bf_s6;
	logic [Q_W-1:0]    bt_s6;
	logic [UV_W-1:0]   bu_s6;
	logic [UV_W-1:0]   bv_s6;

	logic              take1;
	logic              take2;
	logic              mh;
	logic [FACE_W-1:0] mf;
	logic [Q_W-1:0]    mt;
	logic [UV_W-1:0]   mu;
	logic [UV_W-1:0]   mv;

	assign take1 = ch_s5[1] && (!ch_s5[0] || (ct_s5[1] < ct_s5[0]));
	assign mh    = ch_s5[0] || ch_s5[1];
	assign mf    = take1 ? cf_s5[1] : cf_s5[0];
	assign mt    = take1 ? ct_s5[1] : ct_s5[0];
	assign mu    = take1 ? cu_s5[1] : cu_s5[0];
	assign mv    = take1 ? cv_s5[1] : cv_s5[0];
	assign take2 = ch_s5[2] && (!mh || (ct_s5[2] < mt));

	always_ff @(posedge clk) begin
		if (en) begin
			ray_s5 <= ray_s4;
			ray_s6 <= ray_s5;
			bh_s6  <= mh || ch_s5[2];
			bf_s6  <= take2 ? cf_s5[2] : mf;
			bt_s6  <= take2 ? ct_s5[2] : mt;
			bu_s6  <= take2 ? cu_s5[2] : mu;
			bv_s6  <= take2 ? cv_s5[2] : mv;
		end
	end

	// Stage 7: hit point products.
	logic              v_s7;
	ray_t              ray_s7;
	logic              bh_s7;
	logic [FACE_W-1:0] bf_s7;
	logic [Q_W-1:0]    bt_s7;
	logic [UV_W-1:0]   bu_s7;
	logic [UV_W-1:0]   bv_s7;
	logic [PROD_W-1:0] pp_s7 [NUM_AXES];

	for (genvar a = 0; a < NUM_AXES; a++) begin : g_pprod
		always_ff @(posedge clk) begin
			if (en) begin
				pp_s7[a] <= PROD_W'(mag32(ray_s6.dir[a])) * PROD_W'(bt_s6);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ray_s7 <= ray_s6;
			bh_s7  <= bh_s6;
			bf_s7  <= bf_s6;
			bt_s7  <= bt_s6;
			bu_s7  <= bu_s6;
			bv_s7  <= bv_s6;
		end
	end

	// Output register: hit point sums with saturation.
	logic signed [WORD_W-1:0] pt_c [NUM_AXES];

	for (genvar a = 0; a < NUM_AXES; a++) begin : g_point
		logic [PRW-1:0]       m_c;
		logic [SW-1:0]        s_c;
		logic signed [SW-1:0] sum_c;

		assign m_c   = pp_s7[a][PROD_W-1:FRAC_BITS];
		assign s_c   = ray_s7.dir[a][WORD_W-1] ? -SW'(m_c) : SW'(m_c);
		assign sum_c = s_c + SW'($signed(ray_s7.org[a]));
		assign pt_c[a] = (sum_c > P_MAX) ? WORD_W'(P_MAX) :
			(sum_c < P_MIN) ? WORD_W'(P_MIN) : sum_c[WORD_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5        <= 1'b0;
			v_s6        <= 1'b0;
			v_s7        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s5        <= v_s4;
			v_s6        <= v_s5;
			v_s7        <= v_s6;
			out_valid_q <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit     <= bh_s7;
			face    <= bh_s7 ? bf_s7 : '0;
			hit_t   <= bh_s7 ? bt_s7 : '0;
			face_u  <= bh_s7 ? bu_s7 : '0;
			face_v  <= bh_s7 ? bv_s7 : '0;
			point_x <= bh_s7 ? pt_c[0] : '0;
			point_y <= bh_s7 ? pt_c[1] : '0;
			point_z <= bh_s7 ? pt_c[2] : '0;
		end
	end

	// A reported hit always lies strictly between zero and the far limit.
	a_hit_t_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hit |-> (hit_t != '0) && (hit_t != FAR_LIMIT))
		else $error("hit distance out of range");

	// A miss carries an all-zero result.
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit |-> (hit_t == '0) && (face == '0) && (point_x == '0))
		else $error("miss beat carries data");

	// A hidden object enables no face.
	a_hidden: assert property (@(posedge clk) disable iff (!arst_n)
		en && !visible_q |=> ok_s2 == '0)
		else $error("face enabled while hidden");

endmodule

`default_nettype wire
